### rtl/lss_pkg.sv
package lss_pkg;

    // Field widths
    localparam int unsigned QW        = 16;             // Q.8 lengths, speeds, offsets
    localparam int unsigned PW        = 32;             // Q.8 positions
    localparam int unsigned DW        = PW + 1;         // signed position difference
    localparam int unsigned A2W       = QW + 1;         // twice the deceleration

    // Serial arithmetic unit
    localparam int unsigned AccW      = 50;             // product / radicand register
    localparam int unsigned RootW     = AccW / 2;
    localparam int unsigned RemW      = RootW + 2;
    localparam int unsigned MulSteps  = A2W;
    localparam int unsigned SqrtSteps = RootW;
    localparam int unsigned CntW      = $clog2(SqrtSteps + 1);

    // Register port
    localparam int unsigned NumRegs   = 6;
    localparam int unsigned AddrW     = $clog2(NumRegs) + 2;
    localparam int unsigned ApbW      = 32;

    // Register reset values
    localparam logic [QW-1:0] EgoWidthRst   = QW'(512);
    localparam logic [QW-1:0] EgoLengthRst  = QW'(1152);
    localparam logic [QW-1:0] LatMarginRst  = QW'(77);
    localparam logic [QW-1:0] BlockRangeRst = QW'(7680);
    localparam logic [QW-1:0] DecelRst      = QW'(768);
    localparam logic [QW-1:0] FollowBufRst  = QW'(512);

    // Lead must move faster than 0.1 m/s to be followed
    localparam logic [QW-1:0] LeadMin = QW'(25);
    // Stop limit keeps 1 m short of the stop point; inside 0.5 m force zero
    localparam logic signed [DW-1:0] StopMargin = DW'(256);
    localparam logic signed [DW-1:0] StopZone   = DW'(128);

    typedef enum logic [2:0] {
        REG_EGO_WIDTH   = 3'd0,
        REG_EGO_LENGTH  = 3'd1,
        REG_LAT_MARGIN  = 3'd2,
        REG_BLOCK_RANGE = 3'd3,
        REG_DECEL       = 3'd4,
        REG_FOLLOW_BUF  = 3'd5
    } t_reg_idx;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_OBS_A  = 13'b0_0000_0000_0010,
        S_OBS_B  = 13'b0_0000_0000_0100,
        S_OBS_C  = 13'b0_0000_0000_1000,
        S_MUL_V  = 13'b0_0000_0001_0000,
        S_MUL_G  = 13'b0_0000_0010_0000,
        S_SQRT_G = 13'b0_0000_0100_0000,
        S_DIST   = 13'b0_0000_1000_0000,
        S_STOP   = 13'b0_0001_0000_0000,
        S_MUL_T  = 13'b0_0010_0000_0000,
        S_MUL_R  = 13'b0_0100_0000_0000,
        S_SQRT_R = 13'b0_1000_0000_0000,
        S_OUT    = 13'b1_0000_0000_0000
    } t_state;

endpackage

### rtl/lss_if.sv
interface lss_req_if import lss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] lane_offset;
    logic signed [PW-1:0] ref_position;
    logic        [QW-1:0] desired_speed;
    logic signed [PW-1:0] stop_position;
    logic                 stop_enable;
    logic                 obstacle_present;
    logic signed [PW-1:0] obs_position;
    logic signed [QW-1:0] obs_offset;
    logic        [QW-1:0] obs_width;
    logic        [QW-1:0] obs_length;
    logic signed [QW-1:0] obs_speed;
    logic                 last_obstacle;

    modport source (
        output valid, lane_offset, ref_position, desired_speed, stop_position,
               stop_enable, obstacle_present, obs_position, obs_offset,
               obs_width, obs_length, obs_speed, last_obstacle,
        input  ready
    );
    modport sink (
        input  valid, lane_offset, ref_position, desired_speed, stop_position,
               stop_enable, obstacle_present, obs_position, obs_offset,
               obs_width, obs_length, obs_speed, last_obstacle,
        output ready
    );
endinterface

interface lss_res_if import lss_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [QW-1:0] safe_speed;
    logic          path_blocked;

    modport source (output valid, safe_speed, path_blocked, input ready);
    modport sink   (input valid, safe_speed, path_blocked, output ready);
endinterface

### rtl/lane_safe_speed_scan.sv
// Channel   Dir  Handshake        Carries
// i_req     in   valid / ready    one obstacle plus the repeated lane query
// o_res     out  valid / ready    safe_speed, path_blocked at the list end
// apb       in   psel / penable   six 16-bit registers at byte address 4*i
//
// An obstacle item runs through the transfer, then three compare stages
// (difference, overlap and gap, nearest-gap update).
// The list end adds a serial tail: a shift-add multiplier retires one
// multiplier bit a cycle and the square root retires one root bit a cycle;
// up to four products and two roots run one after another on that single unit.
// Reset (synchronous, active low) restores the registers and clears the
// nearest-gap tracking; no clearing pass.
// The result waits in an output register, so the next list is taken while
// o_res stalls; the tail only holds in its last cycle until that register frees.
module lane_safe_speed_scan import lss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lss_req_if.sink          i_req,
    lss_res_if.source        o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [ApbW-1:0]  pwdata,
    output logic [ApbW-1:0]  prdata,
    output logic             pready
);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    t_state r_state, n_state;

    logic [QW-1:0] r_ego_width,   n_ego_width;
    logic [QW-1:0] r_ego_length,  n_ego_length;
    logic [QW-1:0] r_lat_margin,  n_lat_margin;
    logic [QW-1:0] r_block_range, n_block_range;
    logic [QW-1:0] r_decel,       n_decel;
    logic [QW-1:0] r_follow_buf,  n_follow_buf;

    // Held item
    logic signed [QW-1:0] r_lane,  n_lane;
    logic signed [PW-1:0] r_ref,   n_ref;
    logic        [QW-1:0] r_vq,    n_vq;
    logic signed [PW-1:0] r_stop,  n_stop;
    logic                 r_stop_en, n_stop_en;
    logic signed [PW-1:0] r_pos,   n_pos;
    logic signed [QW-1:0] r_off,   n_off;
    logic        [QW-1:0] r_ow,    n_ow;
    logic        [QW-1:0] r_ol,    n_ol;
    logic signed [QW-1:0] r_os,    n_os;
    logic                 r_last,  n_last;

    // Obstacle stages
    logic signed [DW-1:0] r_ld,   n_ld;
    logic signed [QW:0]   r_lat,  n_lat;
    logic        [QW+1:0] r_lim,  n_lim;
    logic        [QW:0]   r_lsum, n_lsum;
    logic                 r_ovl,  n_ovl;
    logic        [PW-1:0] r_cand, n_cand;

    // Tracking across the list
    logic          r_gap_found, n_gap_found;
    logic [PW-1:0] r_nearest,   n_nearest;
    logic [QW-1:0] r_lead,      n_lead;
    logic          r_blocked,   n_blocked;

    // List-end evaluation
    logic        [2*QW-1:0] r_vsq, n_vsq;
    logic        [QW-1:0]   r_spd, n_spd;
    logic signed [DW-1:0]   r_d,   n_d;
    logic        [PW-1:0]   r_rem, n_rem;

    // Shared serial multiplier / square-root unit
    logic [AccW-1:0]  r_mul_a,   n_mul_a;
    logic [A2W-1:0]   r_mul_b,   n_mul_b;
    logic [AccW-1:0]  r_acc,     n_acc;
    logic [CntW-1:0]  r_cnt,     n_cnt;
    logic [RemW-1:0]  r_sq_rem,  n_sq_rem;
    logic [RootW-1:0] r_sq_root, n_sq_root;

    // Output register
    logic          r_out_valid,   n_out_valid;
    logic [QW-1:0] r_out_speed,   n_out_speed;
    logic          r_out_blocked, n_out_blocked;

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    logic                 cfg_wr;
    logic                 out_free;
    logic [A2W-1:0]       a2;
    logic                 in_mul, in_sqrt, unit_done;
    logic [AccW-1:0]      acc_add;
    logic [RemW-1:0]      sq_sh, sq_trial, sq_diff;
    logic                 sq_ge;
    logic                 acc_lt_vsq;
    logic signed [DW-1:0] ld_c, d_c;
    logic signed [QW:0]   lat_c;
    logic        [QW+1:0] lim_c;
    logic        [QW:0]   lsum_c;
    logic        [QW:0]   lat_abs;
    logic                 ahead, ld_near, ovl_c;
    logic signed [DW+1:0] g2_c;
    logic        [PW-1:0] cand_c;
    logic        [QW+1:0] vq3_c;
    logic signed [DW+1:0] t_c;
    logic                 t_pos, t_neg;
    logic signed [DW-1:0] rem_c;
    logic        [PW-1:0] rem_pos_c;
    logic                 d_pos, d_low, stop_cond_c;
    logic        [QW-1:0] root16;
    logic                 follow_lead;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !r_out_valid || o_res.ready;
    assign a2       = {r_decel, 1'b0};

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.safe_speed   = r_out_speed;
    assign o_res.path_blocked = r_out_blocked;

    // Serial unit: one multiplier bit or one root bit per cycle
    assign in_mul    = (r_state == S_MUL_V) || (r_state == S_MUL_G) ||
                       (r_state == S_MUL_T) || (r_state == S_MUL_R);
    assign in_sqrt   = (r_state == S_SQRT_G) || (r_state == S_SQRT_R);
    assign unit_done = (r_cnt == '0);
    assign acc_add   = r_mul_b[0] ? (r_acc + r_mul_a) : r_acc;
    assign sq_sh     = {r_sq_rem[RemW-3:0], r_acc[AccW-1 -: 2]};
    assign sq_trial  = {r_sq_root, 2'b01};
    assign sq_ge     = (sq_sh >= sq_trial);
    assign sq_diff   = sq_sh - sq_trial;
    assign acc_lt_vsq = (r_acc < AccW'(r_vsq));

    // Obstacle stage A: differences and the lateral limit
    assign ld_c   = $signed({r_pos[PW-1], r_pos}) - $signed({r_ref[PW-1], r_ref});
    assign lat_c  = $signed({r_off[QW-1], r_off}) - $signed({r_lane[QW-1], r_lane});
    assign lim_c  = {2'b00, r_ego_width} + {2'b00, r_ow} + {1'b0, r_lat_margin, 1'b0};
    assign lsum_c = {1'b0, r_ego_length} + {1'b0, r_ol};

    // Obstacle stage B: overlap, blocking and gap
    assign lat_abs = r_lat[QW] ? (~r_lat + 1'b1) : r_lat;
    assign ahead   = !r_ld[DW-1] && (r_ld != '0);
    assign ld_near = ($unsigned(r_ld) <= DW'(r_block_range));
    assign ovl_c   = ahead && ({lat_abs, 1'b0} < r_lim);
    assign g2_c    = $signed({r_ld[DW-1], r_ld, 1'b0}) - $signed((DW+2)'(r_lsum));
    assign cand_c  = (!g2_c[DW+1] && (g2_c != '0)) ? g2_c[PW:1] : '0;

    // Stop point: d - 3 s of travel, and d less the 1 m margin
    assign d_c       = $signed({r_stop[PW-1], r_stop}) - $signed({r_ref[PW-1], r_ref});
    assign vq3_c     = {2'b00, r_vq} + {1'b0, r_vq, 1'b0};
    assign t_c       = $signed({r_d[DW-1], r_d[DW-1], r_d}) - $signed((DW+2)'(vq3_c));
    assign t_pos     = !t_c[DW+1] && (t_c != '0);
    assign t_neg     = t_c[DW+1];
    assign rem_c     = r_d - StopMargin;
    assign rem_pos_c = (!rem_c[DW-1] && (rem_c != '0)) ? rem_c[PW-1:0] : '0;
    assign d_pos     = !r_d[DW-1] && (r_d != '0);
    assign d_low     = (r_d < StopZone);
    // With no positive product to form, the braking test reduces to signs
    assign stop_cond_c = (t_neg && (r_decel != '0)) || (r_vsq != '0);

    assign root16      = r_sq_root[QW-1:0];
    assign follow_lead = (r_lead > LeadMin) && (r_nearest > PW'(r_follow_buf)) &&
                         (r_lead > root16);

    // ---------------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------------
    always_comb begin
        n_ego_width   = r_ego_width;
        n_ego_length  = r_ego_length;
        n_lat_margin  = r_lat_margin;
        n_block_range = r_block_range;
        n_decel       = r_decel;
        n_follow_buf  = r_follow_buf;
        prdata        = '0;
        unique case (t_reg_idx'(paddr[AddrW-1:2]))
            REG_EGO_WIDTH: begin
                prdata = ApbW'(r_ego_width);
                if (cfg_wr) n_ego_width = pwdata[QW-1:0];
            end
            REG_EGO_LENGTH: begin
                prdata = ApbW'(r_ego_length);
                if (cfg_wr) n_ego_length = pwdata[QW-1:0];
            end
            REG_LAT_MARGIN: begin
                prdata = ApbW'(r_lat_margin);
                if (cfg_wr) n_lat_margin = pwdata[QW-1:0];
            end
            REG_BLOCK_RANGE: begin
                prdata = ApbW'(r_block_range);
                if (cfg_wr) n_block_range = pwdata[QW-1:0];
            end
            REG_DECEL: begin
                prdata = ApbW'(r_decel);
                if (cfg_wr) n_decel = pwdata[QW-1:0];
            end
            REG_FOLLOW_BUF: begin
                prdata = ApbW'(r_follow_buf);
                if (cfg_wr) n_follow_buf = pwdata[QW-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer and datapath
    // ---------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_lane        = r_lane;
        n_ref         = r_ref;
        n_vq          = r_vq;
        n_stop        = r_stop;
        n_stop_en     = r_stop_en;
        n_pos         = r_pos;
        n_off         = r_off;
        n_ow          = r_ow;
        n_ol          = r_ol;
        n_os          = r_os;
        n_last        = r_last;
        n_ld          = r_ld;
        n_lat         = r_lat;
        n_lim         = r_lim;
        n_lsum        = r_lsum;
        n_ovl         = r_ovl;
        n_cand        = r_cand;
        n_gap_found   = r_gap_found;
        n_nearest     = r_nearest;
        n_lead        = r_lead;
        n_blocked     = r_blocked;
        n_vsq         = r_vsq;
        n_spd         = r_spd;
        n_d           = r_d;
        n_rem         = r_rem;
        n_mul_a       = r_mul_a;
        n_mul_b       = r_mul_b;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_sq_rem      = r_sq_rem;
        n_sq_root     = r_sq_root;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_speed   = r_out_speed;
        n_out_blocked = r_out_blocked;

        // Advance the serial unit; the state arms below act on completion
        if (in_mul && !unit_done) begin
            n_acc   = acc_add;
            n_mul_a = r_mul_a << 1;
            n_mul_b = r_mul_b >> 1;
            n_cnt   = r_cnt - 1'b1;
        end
        if (in_sqrt && !unit_done) begin
            n_acc     = r_acc << 2;
            n_sq_rem  = sq_ge ? sq_diff : sq_sh;
            n_sq_root = {r_sq_root[RootW-2:0], sq_ge};
            n_cnt     = r_cnt - 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_lane    = i_req.lane_offset;
                    n_ref     = i_req.ref_position;
                    n_vq      = i_req.desired_speed;
                    n_stop    = i_req.stop_position;
                    n_stop_en = i_req.stop_enable;
                    n_pos     = i_req.obs_position;
                    n_off     = i_req.obs_offset;
                    n_ow      = i_req.obs_width;
                    n_ol      = i_req.obs_length;
                    n_os      = i_req.obs_speed;
                    n_last    = !i_req.obstacle_present || i_req.last_obstacle;
                    if (i_req.obstacle_present) begin
                        n_state = S_OBS_A;
                    end else begin
                        // Empty item: go straight to the list-end tail
                        n_mul_a = AccW'(i_req.desired_speed);
                        n_mul_b = A2W'(i_req.desired_speed);
                        n_acc   = '0;
                        n_cnt   = CntW'(MulSteps);
                        n_state = S_MUL_V;
                    end
                end
            end
            S_OBS_A: begin
                n_ld    = ld_c;
                n_lat   = lat_c;
                n_lim   = lim_c;
                n_lsum  = lsum_c;
                n_state = S_OBS_B;
            end
            S_OBS_B: begin
                n_ovl  = ovl_c;
                n_cand = cand_c;
                if (ovl_c && ld_near) n_blocked = 1'b1;
                n_state = S_OBS_C;
            end
            S_OBS_C: begin
                // Keep only a strictly nearer gap
                if (r_ovl && (!r_gap_found || (r_cand < r_nearest))) begin
                    n_gap_found = 1'b1;
                    n_nearest   = r_cand;
                    n_lead      = (r_os[QW-1] || (r_os == '0)) ? '0 : r_os;
                end
                if (r_last) begin
                    n_mul_a = AccW'(r_vq);
                    n_mul_b = A2W'(r_vq);
                    n_acc   = '0;
                    n_cnt   = CntW'(MulSteps);
                    n_state = S_MUL_V;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL_V: begin
                if (unit_done) begin
                    n_vsq = r_acc[2*QW-1:0];
                    n_spd = r_vq;
                    if (r_gap_found) begin
                        n_mul_a = AccW'(r_nearest);
                        n_mul_b = a2;
                        n_acc   = '0;
                        n_cnt   = CntW'(MulSteps);
                        n_state = S_MUL_G;
                    end else begin
                        n_state = S_DIST;
                    end
                end
            end
            S_MUL_G: begin
                if (unit_done) begin
                    if (acc_lt_vsq) begin
                        n_sq_rem  = '0;
                        n_sq_root = '0;
                        n_cnt     = CntW'(SqrtSteps);
                        n_state   = S_SQRT_G;
                    end else begin
                        n_state = S_DIST;
                    end
                end
            end
            S_SQRT_G: begin
                if (unit_done) begin
                    n_spd   = follow_lead ? r_lead : root16;
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                n_d     = d_c;
                n_state = S_STOP;
            end
            S_STOP: begin
                n_rem = rem_pos_c;
                priority if (!r_stop_en || !d_pos) begin
                    n_state = S_OUT;
                end else if (t_pos) begin
                    n_mul_a = AccW'(t_c[PW-1:0]);
                    n_mul_b = a2;
                    n_acc   = '0;
                    n_cnt   = CntW'(MulSteps);
                    n_state = S_MUL_T;
                end else if (stop_cond_c) begin
                    n_mul_a = AccW'(rem_pos_c);
                    n_mul_b = a2;
                    n_acc   = '0;
                    n_cnt   = CntW'(MulSteps);
                    n_state = S_MUL_R;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL_T: begin
                if (unit_done) begin
                    if (acc_lt_vsq) begin
                        n_mul_a = AccW'(r_rem);
                        n_mul_b = a2;
                        n_acc   = '0;
                        n_cnt   = CntW'(MulSteps);
                        n_state = S_MUL_R;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL_R: begin
                // Take the root of the stop-point radicand on the shared unit
                if (unit_done) begin
                    n_sq_rem  = '0;
                    n_sq_root = '0;
                    n_cnt     = CntW'(SqrtSteps);
                    n_state   = S_SQRT_R;
                    n_mul_b   = '0;
                end
            end
            S_SQRT_R: begin
                // Lower the speed to the stop-point root; compare the full root width
                if (unit_done) begin
                    if (r_sq_root < RootW'(r_spd)) n_spd = root16;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_speed   = (r_stop_en && d_low) ? '0 : r_spd;
                    n_out_blocked = r_blocked;
                    n_gap_found   = 1'b0;
                    n_nearest     = '1;
                    n_lead        = '0;
                    n_blocked     = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_gap_found   <= 1'b0;
            r_nearest     <= '1;
            r_lead        <= '0;
            r_blocked     <= 1'b0;
            r_ego_width   <= EgoWidthRst;
            r_ego_length  <= EgoLengthRst;
            r_lat_margin  <= LatMarginRst;
            r_block_range <= BlockRangeRst;
            r_decel       <= DecelRst;
            r_follow_buf  <= FollowBufRst;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_gap_found   <= n_gap_found;
            r_nearest     <= n_nearest;
            r_lead        <= n_lead;
            r_blocked     <= n_blocked;
            r_ego_width   <= n_ego_width;
            r_ego_length  <= n_ego_length;
            r_lat_margin  <= n_lat_margin;
            r_block_range <= n_block_range;
            r_decel       <= n_decel;
            r_follow_buf  <= n_follow_buf;
        end
    end

    // ---------------------------------------------------------------------
    // Payload
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_lane        <= n_lane;
        r_ref         <= n_ref;
        r_vq          <= n_vq;
        r_stop        <= n_stop;
        r_stop_en     <= n_stop_en;
        r_pos         <= n_pos;
        r_off         <= n_off;
        r_ow          <= n_ow;
        r_ol          <= n_ol;
        r_os          <= n_os;
        r_last        <= n_last;
        r_ld          <= n_ld;
        r_lat         <= n_lat;
        r_lim         <= n_lim;
        r_lsum        <= n_lsum;
        r_ovl         <= n_ovl;
        r_cand        <= n_cand;
        r_vsq         <= n_vsq;
        r_spd         <= n_spd;
        r_d           <= n_d;
        r_rem         <= n_rem;
        r_mul_a       <= n_mul_a;
        r_mul_b       <= n_mul_b;
        r_acc         <= n_acc;
        r_cnt         <= n_cnt;
        r_sq_rem      <= n_sq_rem;
        r_sq_root     <= n_sq_root;
        r_out_speed   <= n_out_speed;
        r_out_blocked <= n_out_blocked;
    end

`ifndef NO_ASSERTIONS
    // Restoring root: the partial remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_sqrt |-> (r_sq_rem <= RemW'({r_sq_root, 1'b0})))
        else $error("square root remainder out of bound");

    // A result leaves the tail together with the cleared tracking state
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
        (r_state == S_IDLE && !r_gap_found && !r_blocked && r_out_valid))
        else $error("tracking state not cleared with the result");

    // The output register is only loaded by the tail
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the output step");

    // Products stay inside the accumulator
    a_acc_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_mul && unit_done) |-> (r_acc[AccW-1] == 1'b0))
        else $error("product overflowed the accumulator");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb import lss_pkg::*; ();

    // One item as offered on the request channel: the lane query plus one obstacle
    typedef struct {
        bit signed [QW-1:0] lane_offset;
        bit signed [PW-1:0] ref_position;
        bit        [QW-1:0] desired_speed;
        bit signed [PW-1:0] stop_position;
        bit                 stop_enable;
        bit                 obstacle_present;
        bit signed [PW-1:0] obs_position;
        bit signed [QW-1:0] obs_offset;
        bit        [QW-1:0] obs_width;
        bit        [QW-1:0] obs_length;
        bit signed [QW-1:0] obs_speed;
        bit                 last_obstacle;
    } t_scan_item;

    typedef struct {
        bit [QW-1:0] speed;
        bit          blocked;
    } t_speed_limit;

    // Predicts the speed limit of each obstacle list and checks the block against it
    class safe_speed_board;
        longint       ego_width, ego_length, lat_margin, block_range, decel, follow_buf;
        bit [PW-1:0]  nearest_gap;
        bit [QW-1:0]  lead_speed;
        bit           gap_found;
        bit           blocked;
        t_speed_limit expected_limits[$];
        int           errors;

        function new();
            ego_width   = 512;
            ego_length  = 1152;
            lat_margin  = 77;
            block_range = 7680;
            decel       = 768;
            follow_buf  = 512;
            errors      = 0;
            clear_list();
        endfunction

        function void clear_list();
            nearest_gap = '1;
            lead_speed  = '0;
            gap_found   = 1'b0;
            blocked     = 1'b0;
        endfunction

        function void set_register(t_reg_idx idx, bit [QW-1:0] value);
            case (idx)
                REG_EGO_WIDTH:   ego_width   = value;
                REG_EGO_LENGTH:  ego_length  = value;
                REG_LAT_MARGIN:  lat_margin  = value;
                REG_BLOCK_RANGE: block_range = value;
                REG_DECEL:       decel       = value;
                REG_FOLLOW_BUF:  follow_buf  = value;
                default: ;
            endcase
        endfunction

        function longint root_floor(longint x);
            longint r;
            longint t;
            r = 0;
            for (int b = 26; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        function int pending();
            return expected_limits.size();
        endfunction

        function void note_request(t_scan_item q);
            longint lane, refp, v, ld, lat, g2, a2, vsq, spd, d, rem, ss, gap_q, lead_q;
            longint pos, off, ow, ol, os;
            bit [PW-1:0] gap;
            t_speed_limit res;
            lane = q.lane_offset;
            refp = q.ref_position;
            v    = q.desired_speed;
            if (q.obstacle_present) begin
                pos = q.obs_position;
                off = q.obs_offset;
                ow  = q.obs_width;
                ol  = q.obs_length;
                os  = q.obs_speed;
                ld  = pos - refp;
                if (ld > 0) begin
                    lat = off - lane;
                    if (lat < 0)
                        lat = -lat;
                    if (2 * lat < ego_width + ow + 2 * lat_margin) begin
                        g2  = 2 * ld - ol - ego_length;
                        gap = (g2 > 0) ? PW'(g2 >>> 1) : '0;
                        if (ld <= block_range)
                            blocked = 1'b1;
                        if (!gap_found || gap < nearest_gap) begin
                            gap_found   = 1'b1;
                            nearest_gap = gap;
                            lead_speed  = (os > 0) ? QW'(os) : '0;
                        end
                    end
                end
            end
            if (q.obstacle_present && !q.last_obstacle)
                return;

            a2     = 2 * decel;
            vsq    = v * v;
            spd    = v;
            gap_q  = nearest_gap;
            lead_q = lead_speed;
            if (gap_found && a2 * gap_q < vsq) begin
                spd = root_floor(a2 * gap_q);
                // follow a moving lead once the gap exceeds the buffer
                if (lead_q > 25 && gap_q > follow_buf && lead_q > spd)
                    spd = lead_q;
            end
            if (q.stop_enable) begin
                d = longint'(q.stop_position) - refp;
                if (d > 0 && a2 * (d - 3 * v) < vsq) begin
                    rem = d - 256;
                    if (rem < 0)
                        rem = 0;
                    ss = root_floor(a2 * rem);
                    if (ss < spd)
                        spd = ss;
                end
                if (d < 128)
                    spd = 0;
            end
            if (spd > 65535)
                spd = 65535;
            res.speed   = QW'(spd);
            res.blocked = blocked;
            expected_limits.push_back(res);
            clear_list();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [QW-1:0] speed, logic blk);
            t_speed_limit want;
            if (expected_limits.size() == 0) begin
                report_mismatch($sformatf("result with none pending: speed %0d blocked %b",
                                          speed, blk));
                return;
            end
            want = expected_limits.pop_front();
            if (speed !== want.speed)
                report_mismatch($sformatf("safe_speed %0d, predicted %0d", speed, want.speed));
            if (blk !== want.blocked)
                report_mismatch($sformatf("path_blocked %b, predicted %b", blk, want.blocked));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [ApbW-1:0]  pwdata;
    logic [ApbW-1:0]  prdata;
    logic             pready;

    lss_req_if req_ch();
    lss_res_if res_ch();

    lane_safe_speed_scan u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    safe_speed_board board = new();

    int tx_idle_pct   = 0;   // chance in a hundred that the sender skips a cycle
    int rx_idle_pct   = 0;   // chance in a hundred that the receiver drops ready
    int hold_requests = 0;   // each increment asks the receiver for one long hold-off
    int items_sent    = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop, well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: check each result transfer, then decide ready for the next cycle.
    // A long hold-off is counted here so that the sender keeps offering meanwhile.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                board.check_result(res_ch.safe_speed, res_ch.path_blocked);
            if (hold_left == 0 && holds_served != hold_requests) begin
                hold_left = 400;
                holds_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item, idling first at the current rate; return at the accepting edge
    // with valid still high so that back-to-back items need no second assignment.
    task automatic send_item(t_scan_item q);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.lane_offset      <= q.lane_offset;
        req_ch.ref_position     <= q.ref_position;
        req_ch.desired_speed    <= q.desired_speed;
        req_ch.stop_position    <= q.stop_position;
        req_ch.stop_enable      <= q.stop_enable;
        req_ch.obstacle_present <= q.obstacle_present;
        req_ch.obs_position     <= q.obs_position;
        req_ch.obs_offset       <= q.obs_offset;
        req_ch.obs_width        <= q.obs_width;
        req_ch.obs_length       <= q.obs_length;
        req_ch.obs_speed        <= q.obs_speed;
        req_ch.last_obstacle    <= q.last_obstacle;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        board.note_request(q);
        items_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    // Leave psel high; the caller returns the port to idle after the last write.
    task automatic write_reg(t_reg_idx idx, bit [QW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ApbW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_register(idx, value);
    endtask

    task automatic write_settings(bit [QW-1:0] vals [NumRegs]);
        for (int i = 0; i < NumRegs; i++)
            write_reg(t_reg_idx'(i), vals[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_scan_item scan_item(int lane, int refp, int v, int stopp, bit sen,
                                             bit pres, int pos, int off, int w, int len,
                                             int spd, bit last);
        t_scan_item q;
        q.lane_offset      = QW'(lane);
        q.ref_position     = refp;
        q.desired_speed    = QW'(v);
        q.stop_position    = stopp;
        q.stop_enable      = sen;
        q.obstacle_present = pres;
        q.obs_position     = pos;
        q.obs_offset       = QW'(off);
        q.obs_width        = QW'(w);
        q.obs_length       = QW'(len);
        q.obs_speed        = QW'(spd);
        q.last_obstacle    = last;
        return q;
    endfunction

    function automatic t_scan_item noise_item();
        return scan_item($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                         1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, 1'($urandom_range(1)));
    endfunction

    // Hand-picked lists under the reset settings: empty lists, obstacles behind and
    // level, the lateral overlap edge, nearest-gap replacement and ties, following a
    // lead, negative lead speed, the stop limit and its forced zero, and extremes.
    task automatic send_directed();
        int lo = -32'sd2147483648;
        int hi = 32'sd2147483647;
        // empty item ends the list whatever last_obstacle says
        send_item(scan_item(0, 0, 2560, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(scan_item(0, 0, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // single obstacle ahead and overlapping, inside blocking range
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 5120, 0, 512, 1152, 0, 1));
        // behind and level with the own vehicle: ignored
        send_item(scan_item(0, 1000, 7680, 0, 0, 1, 900, 0, 512, 1152, 900, 1));
        send_item(scan_item(0, 1000, 7680, 0, 0, 1, 1000, 0, 512, 1152, 900, 1));
        // lateral overlap edge: just clear, then just touching
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 3000, 589, 512, 1152, 900, 1));
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 3000, 588, 512, 1152, 900, 1));
        // nearer obstacle replaces the kept one, an equal gap does not; follow the lead
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 20000, 0, 512, 1152, 1000, 0));
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 10000, 0, 512, 1152, 5000, 0));
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 10000, 0, 512, 1152, 6000, 1));
        // lead speed at the follow threshold and just above, and a reversing lead
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 10000, 0, 512, 1152, 25, 1));
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 10000, 0, 512, 1152, 26, 1));
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 4000, 0, 512, 1152, -5000, 1));
        // stop point ahead limits speed; inside half a metre or behind forces zero
        send_item(scan_item(0, 0, 7680, 20000, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(scan_item(0, 0, 100, 127, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(scan_item(0, 0, 100, 128, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(scan_item(0, 0, 7680, -1000, 1, 0, 0, 0, 0, 0, 0, 1));
        // stop disabled: no limit even at the stop point
        send_item(scan_item(0, 0, 7680, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // field extremes, overlapping and not
        send_item(scan_item(-32768, lo, 65535, hi, 1, 1, hi, -32768, 65535, 65535, 32767,
                            1));
        send_item(scan_item(-32768, lo, 65535, hi, 1, 1, hi, 32767, 65535, 65535, -32768,
                            1));
        send_item(scan_item(32767, hi, 0, lo, 1, 1, lo, 32767, 0, 0, 0, 1));
        // the list end takes the query of its own item, not of the earlier ones
        send_item(scan_item(0, 0, 7680, 0, 0, 1, 3000, 0, 512, 1152, 900, 0));
        send_item(scan_item(300, 500, 2000, 9000, 1, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // One well-formed list: a shared lane query with obstacles around the lane
    // and ahead, with the odd wild field to keep the corners in play.
    task automatic send_random_list();
        t_scan_item q;
        int count;
        q = noise_item();
        count = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        q.lane_offset   = ($urandom_range(4) == 0) ? QW'($urandom)
                                                   : QW'(int'($urandom_range(1600)) - 800);
        q.ref_position  = int'($urandom) >>> 2;
        q.desired_speed = ($urandom_range(3) == 0) ? QW'($urandom)
                                                   : QW'($urandom_range(9000));
        q.stop_enable   = 1'($urandom_range(1));
        q.stop_position = ($urandom_range(4) == 0) ? $urandom
                        : q.ref_position + int'($urandom_range(40000)) - 600;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
                q.desired_speed = QW'($urandom_range(9000));
                q.lane_offset   = QW'(q.lane_offset + int'($urandom_range(400)) - 200);
            end
            q.obstacle_present = 1'b1;
            // sometimes repeat the previous position and length to tie the gap
            if (i == 0 || $urandom_range(6) != 0) begin
                q.obs_position = ($urandom_range(9) == 0) ? $urandom
                               : q.ref_position + int'($urandom_range(22000)) - 1500;
                q.obs_length   = ($urandom_range(9) == 0) ? QW'($urandom)
                                                          : QW'($urandom_range(1500));
            end
            q.obs_offset    = ($urandom_range(5) == 0) ? QW'($urandom)
                            : QW'(q.lane_offset + int'($urandom_range(1600)) - 800);
            q.obs_width     = ($urandom_range(9) == 0) ? QW'($urandom)
                                                       : QW'($urandom_range(700));
            q.obs_speed     = ($urandom_range(5) == 0) ? QW'($urandom)
                            : QW'(int'($urandom_range(8500)) - 500);
            q.last_obstacle = (i == count - 1);
            if (i == count - 1 && $urandom_range(4) == 0) begin
                q.obstacle_present = 1'b0;
                q.last_obstacle    = 1'($urandom_range(1));
            end
            send_item(q);
        end
    endtask

    initial begin
        bit [QW-1:0] vals [NumRegs];
        t_scan_item  closing;
        int          phase_start;
        bit          paused;

        // initialise every input before the first edge
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        req_ch.valid            <= 1'b0;
        req_ch.lane_offset      <= '0;
        req_ch.ref_position     <= '0;
        req_ch.desired_speed    <= '0;
        req_ch.stop_position    <= '0;
        req_ch.stop_enable      <= 1'b0;
        req_ch.obstacle_present <= 1'b0;
        req_ch.obs_position     <= '0;
        req_ch.obs_offset       <= '0;
        req_ch.obs_width        <= '0;
        req_ch.obs_length       <= '0;
        req_ch.obs_speed        <= '0;
        req_ch.last_obstacle    <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Six phases, each under its own register settings. The first runs on the
        // reset values; then all zeros (zero deceleration), all ones, plausible
        // values, anything, and the reset values written back.
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 83 : 0;
            rx_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 23 : 0;
            if (ph > 0) begin
                for (int i = 0; i < NumRegs; i++) begin
                    case (ph)
                        1: vals[i] = '0;
                        2: vals[i] = '1;
                        4: vals[i] = QW'($urandom);
                        default: vals[i] = '0;
                    endcase
                end
                if (ph == 3) begin
                    vals[REG_EGO_WIDTH]   = QW'($urandom_range(300, 700));
                    vals[REG_EGO_LENGTH]  = QW'($urandom_range(800, 1500));
                    vals[REG_LAT_MARGIN]  = QW'($urandom_range(200));
                    vals[REG_BLOCK_RANGE] = QW'($urandom_range(20000));
                    vals[REG_DECEL]       = QW'($urandom_range(1, 2000));
                    vals[REG_FOLLOW_BUF]  = QW'($urandom_range(3000));
                end
                if (ph == 5)
                    vals = '{512, 1152, 77, 7680, 768, 512};
                write_settings(vals);
                @(posedge i_clk);
            end
            if (ph == 0)
                send_directed();
            // hold the receiver off for a long stretch while items keep coming
            if (ph == 4)
                hold_requests++;
            phase_start = items_sent;
            paused      = 1'b0;
            while (items_sent - phase_start < 215) begin
                // once, pause the sender until every result is back
                if (ph == 5 && !paused && items_sent - phase_start >= 100) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 3))
                        send_item(noise_item());
                end else begin
                    send_random_list();
                end
            end
            // close any list left open by noise before the settings change
            closing = noise_item();
            closing.obstacle_present = 1'b0;
            send_item(closing);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
